>>> hw/rtl/pcad_pkg.sv
// ----------------------------------------------------------------------------
// pcad_pkg: shared types and constants
// Widths of the CORDIC and square-root datapath, the arctangent table and the
// record that moves from cell to cell.
// ----------------------------------------------------------------------------
package pcad_pkg;

	localparam int CW          = 44;  // CORDIC x/y, signed, 2^40 full scale
	localparam int NW          = 44;  // square-root radicand
	localparam int RW          = 26;  // square-root partial remainder
	localparam int ROOT_W      = 22;  // square-root result bits
	localparam int SQRT_DIGITS = 22;  // one radicand bit pair per cell
	localparam int SAT_BIT     = 17;  // |dx| or |dy| at or above 2^17 saturates

	localparam logic [15:0] ANGLE_FULL = 16'd46080;      // 360 deg in 1/128 deg
	localparam logic [31:0] HALF_TURN  = 32'h8000_0000;  // 180 deg, binary angle
	localparam logic [20:0] DIST_MAX   = 21'h1F_FFFF;

	// round(atan(2^-i) * 2^32 / 2pi)
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          acc;
		logic [NW-1:0]        n;
		logic [RW-1:0]        rem;
		logic [ROOT_W-1:0]    root;
		logic                 sat;
		logic                 zero;
		logic                 action;
	} cell_data_t;

endpackage

>>> hw/rtl/point_polar_angle_distance.sv
// ----------------------------------------------------------------------------
// point_polar_angle_distance: polar angle and distance of a point
// Rectangular-to-polar conversion of (point - reference) by a chain of
// CORDIC vectoring cells, with a digit-by-digit square root for the length
// riding along in the same cells.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------
//  pt       pt_valid / pt_stall  action, point_x, point_y, ref_x, ref_y
//  res      res_valid/res_stall  angle_deg (1/128 deg), distance (1/16 unit)
//
// One beat in per cycle and one beat out per cycle while the result channel
// is not stalled. The chain has three front stages, one cell per CORDIC
// rotation or square-root digit pair, and two output stages.
// Each stage holds its beat only while the next one holds and the result is
// stalled, so bubbles collapse and pt_stall rises only with a full chain.
// arst_n clears the valid flags only; payload registers are not reset.
//
// Angle: 32-bit binary angle, rounded to 1/128 degree, 360 wraps to 0.
// A zero difference gives 0 (or 180 deg with action set), distance 0.
// Distance saturates at 2^21-1 when |dx| or |dy| reaches 2^17.

module point_polar_angle_distance
	import pcad_pkg::*;
#(
	parameter int COORD_BITS    = 16,
	parameter int CORDIC_STAGES = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pt_valid,
	output logic                         pt_stall,
	input  logic                         action,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] ref_x,
	input  logic signed [COORD_BITS-1:0] ref_y,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [15:0]                  angle_deg,
	output logic [20:0]                  distance
);

	// cells needed: whichever of the rotations and root digits is longer
	localparam int N = (CORDIC_STAGES > SQRT_DIGITS) ? CORDIC_STAGES : SQRT_DIGITS;

	logic       chain_valid [N+1];
	logic       chain_stall [N+1];
	cell_data_t chain_data  [N+1];

	pcad_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.action   (action),
		.point_x  (point_x),
		.point_y  (point_y),
		.ref_x    (ref_x),
		.ref_y    (ref_y),
		.dn_valid (chain_valid[0]),
		.dn_data  (chain_data[0]),
		.dn_stall (chain_stall[0])
	);

	// the chain: cell k does rotation k if k < CORDIC_STAGES and root digit pair k if k < SQRT_DIGITS
	for (genvar k = 0; k < N; k++) begin : g_cell
		pcad_cell #(
			.IDX           (k),
			.CORDIC_STAGES (CORDIC_STAGES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[k]),
			.up_data  (chain_data[k]),
			.up_stall (chain_stall[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_data  (chain_data[k+1]),
			.dn_stall (chain_stall[k+1])
		);
	end

	pcad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (chain_valid[N]),
		.up_data   (chain_data[N]),
		.up_stall  (chain_stall[N]),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.angle_deg (angle_deg),
		.distance  (distance)
	);

	// input side backs up only behind a stalled, occupied output
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		pt_stall |-> (res_valid && res_stall))
		else $error("pt_stall without a stalled result beat");

	// last cell is held only while the result channel is stalled
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chain_stall[N] |-> res_stall)
		else $error("chain held with result channel free");

	// wrap of 360 deg to 0 must have happened
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (angle_deg < ANGLE_FULL))
		else $error("angle_deg out of range");

endmodule

>>> hw/rtl/pcad_front.sv
// ----------------------------------------------------------------------------
// pcad_front: difference, scaling and radicand
// Three stages: point minus reference; CORDIC start vector and squares;
// radicand 256*(dx^2+dy^2).
// ----------------------------------------------------------------------------
module pcad_front
	import pcad_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pt_valid,
	output logic                         pt_stall,
	input  logic                         action,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] ref_x,
	input  logic signed [COORD_BITS-1:0] ref_y,
	output logic                         dn_valid,
	output cell_data_t                   dn_data,
	input  logic                         dn_stall
);

	localparam int DW = COORD_BITS + 1;
	localparam int SH = 40 - COORD_BITS;
	localparam int AW = (DW > SAT_BIT + 1) ? DW : SAT_BIT + 1;

	// stage 1
	logic                 valid_s1, action_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	// stage 2
	logic                 valid_s2, action_s2, sat_s2, zero_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic [31:0]          acc_s2;
	logic [2*SAT_BIT-1:0] sqx_s2, sqy_s2;
	// stage 3
	logic                 valid_s3;
	cell_data_t           data_s3;

	logic                 stall_s1, stall_s2, stall_s3;
	logic signed [CW-1:0] xe, ye, xsc, ysc;
	logic signed [AW-1:0] dxw, dyw;
	logic [AW-1:0]        ax, ay;
	logic                 neg;
	logic [2*SAT_BIT:0]   sq_sum;

	assign stall_s3 = valid_s3 & dn_stall;
	assign stall_s2 = valid_s2 & stall_s3;
	assign stall_s1 = valid_s1 & stall_s2;
	assign pt_stall = stall_s1;

	always_comb begin
		xe  = CW'(dx_s1);
		ye  = CW'(dy_s1);
		xsc = xe <<< SH;
		ysc = ye <<< SH;
		neg = dx_s1[DW-1];
		dxw = AW'(dx_s1);
		dyw = AW'(dy_s1);
		ax  = dx_s1[DW-1] ? AW'(-dxw) : AW'(dxw);
		ay  = dy_s1[DW-1] ? AW'(-dyw) : AW'(dyw);
		sq_sum = (2*SAT_BIT+1)'(sqx_s2) + (2*SAT_BIT+1)'(sqy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!stall_s1) valid_s1 <= pt_valid;
			if (!stall_s2) valid_s2 <= valid_s1;
			if (!stall_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && pt_valid) begin
			dx_s1     <= DW'(point_x) - DW'(ref_x);
			dy_s1     <= DW'(point_y) - DW'(ref_y);
			action_s1 <= action;
		end
		if (!stall_s2 && valid_s1) begin
			// fold left half-plane onto the right, start at 180 deg
			x_s2      <= neg ? -xsc : xsc;
			y_s2      <= neg ? -ysc : ysc;
			acc_s2    <= neg ? HALF_TURN : 32'd0;
			sat_s2    <= (ax >> SAT_BIT) != '0 || (ay >> SAT_BIT) != '0;
			zero_s2   <= (dx_s1 == '0) && (dy_s1 == '0);
			action_s2 <= action_s1;
			sqx_s2    <= ax[SAT_BIT-1:0] * ax[SAT_BIT-1:0];
			sqy_s2    <= ay[SAT_BIT-1:0] * ay[SAT_BIT-1:0];
		end
		if (!stall_s3 && valid_s2) begin
			data_s3.x      <= x_s2;
			data_s3.y      <= y_s2;
			data_s3.acc    <= acc_s2;
			data_s3.n      <= sat_s2 ? '0 : NW'({sq_sum, 8'd0});
			data_s3.rem    <= '0;
			data_s3.root   <= '0;
			data_s3.sat    <= sat_s2;
			data_s3.zero   <= zero_s2;
			data_s3.action <= action_s2;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

>>> hw/rtl/pcad_cell.sv
// ----------------------------------------------------------------------------
// pcad_cell: one link of the chain
// One CORDIC vectoring rotation and one square-root digit per cell, each only
// while IDX is below its limit, then a register that hands the record to the next cell.
// ----------------------------------------------------------------------------
module pcad_cell
	import pcad_pkg::*;
#(
	parameter int IDX           = 0,
	parameter int CORDIC_STAGES = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	input  cell_data_t up_data,
	output logic       up_stall,
	output logic       dn_valid,
	output cell_data_t dn_data,
	input  logic       dn_stall
);

	logic                 valid_s1;
	cell_data_t           data_s1, nxt;
	logic signed [CW-1:0] xs, ys;
	logic [RW-1:0]        rem2, trial;

	assign up_stall = valid_s1 & dn_stall;

	always_comb begin
		nxt   = up_data;
		xs    = up_data.x >>> IDX;
		ys    = up_data.y >>> IDX;
		rem2  = {up_data.rem[RW-3:0], up_data.n[NW-1 -: 2]};
		trial = RW'({up_data.root, 2'b01});
		if (IDX < CORDIC_STAGES) begin
			if (!up_data.y[CW-1]) begin
				nxt.x   = up_data.x + ys;
				nxt.y   = up_data.y - xs;
				nxt.acc = up_data.acc + ATAN_TAB[5'(IDX)];
			end else begin
				nxt.x   = up_data.x - ys;
				nxt.y   = up_data.y + xs;
				nxt.acc = up_data.acc - ATAN_TAB[5'(IDX)];
			end
		end
		if (IDX < SQRT_DIGITS) begin
			nxt.n = up_data.n << 2;
			if (rem2 >= trial) begin
				nxt.rem  = rem2 - trial;
				nxt.root = {up_data.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rem2;
				nxt.root = {up_data.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

>>> hw/rtl/pcad_back.sv
// ----------------------------------------------------------------------------
// pcad_back: result formatting
// Binary angle to 1/128 degree with rounding and wrap, distance rounding and
// saturation, and the output register.
// ----------------------------------------------------------------------------
module pcad_back
	import pcad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	input  cell_data_t  up_data,
	output logic        up_stall,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] angle_deg,
	output logic [20:0] distance
);

	logic              valid_s1, valid_s2, sat_s1;
	logic [47:0]       prod_s1;
	logic [ROOT_W:0]   dist_s1;
	logic [15:0]       angle_s2;
	logic [20:0]       dist_s2;
	logic              stall_s1, stall_s2;
	logic [31:0]       acc_a;
	logic [ROOT_W:0]   rnd;
	logic [47:0]       prod_r;
	logic [15:0]       ang;

	assign stall_s2 = valid_s2 & res_stall;
	assign stall_s1 = valid_s1 & stall_s2;
	assign up_stall = stall_s1;

	always_comb begin
		// a zero difference has no direction: force 0 deg before the action turn
		acc_a  = (up_data.zero ? 32'd0 : up_data.acc) +
		         (up_data.action ? HALF_TURN : 32'd0);
		rnd    = (ROOT_W+1)'(up_data.root) +
		         (ROOT_W+1)'(up_data.rem > RW'(up_data.root));
		prod_r = prod_s1 + 48'(HALF_TURN);
		ang    = prod_r[47:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!stall_s1) valid_s1 <= up_valid;
			if (!stall_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			prod_s1 <= 48'(acc_a) * 48'(ANGLE_FULL);
			dist_s1 <= rnd;
			sat_s1  <= up_data.sat;
		end
		if (!stall_s2 && valid_s1) begin
			angle_s2 <= (ang == ANGLE_FULL) ? 16'd0 : ang;
			dist_s2  <= (sat_s1 || dist_s1 > (ROOT_W+1)'(DIST_MAX)) ? DIST_MAX
			            : dist_s1[20:0];
		end
	end

	assign res_valid = valid_s2;
	assign angle_deg = angle_s2;
	assign distance  = dist_s2;

endmodule

>>> sim/tb_point_polar_angle_distance.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_polar_angle_distance: self-checking bench for the polar converter
// A table of directed point pairs is followed by random pairs under three
// idle patterns. Each accepted beat is run through a CORDIC and square-root
// predictor, and every result beat is compared in order with it.
// ----------------------------------------------------------------------------

module tb_point_polar_angle_distance;

	localparam int LATENCY          = 27;
	localparam int STALL_LIMIT      = 2000;  // cycles with no beat on either side
	localparam int RANDOM_PER_PHASE = 667;
	localparam int ROTATIONS        = 20;
	localparam int SCALE_SHIFT      = 24;    // 40 - coordinate width, a scale of 2^24
	localparam int SAT_MAG          = 1 << 17;

	localparam logic [31:0] HALF_REV   = 32'h8000_0000;
	localparam logic [63:0] FULL_CIRC  = 64'd46080;
	localparam logic [63:0] DIST_SAT   = 64'h1F_FFFF;
	localparam int          NA         = -1;  // no typed expectation, use predictor

	localparam logic signed [15:0] CMAX = 16'sh7FFF;
	localparam logic signed [15:0] CMIN = 16'sh8000;
	localparam logic signed [15:0] Z    = 16'sd0;

	localparam logic signed [15:0] EXTREMES [4] = '{CMAX, CMIN, 16'sd0, -16'sd1};

	// binary-angle arctangent steps, 2^32 per revolution
	localparam logic [31:0] ARCTAN_STEP [ROTATIONS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	typedef struct packed {
		logic               act;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} pt_beat_t;

	typedef struct packed {
		logic [15:0] angle;
		logic [20:0] radius;
	} polar_t;

	typedef struct packed {
		logic               act;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		int                 exp_angle;
		int                 exp_dist;
	} point_row_t;

	localparam int DIRECTED_ROWS = 24;

	// act, point x/y, reference x/y, typed angle, typed distance
	localparam point_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b0, Z, Z, Z, Z, 0, 0},                          // zero difference
		'{1'b1, Z, Z, Z, Z, 23040, 0},                      // zero, from -x axis
		'{1'b0, CMAX, CMIN, CMAX, CMIN, 0, 0},
		'{1'b1, CMIN, CMAX, CMIN, CMAX, 23040, 0},
		'{1'b0, CMAX, Z, CMIN, Z, NA, 1048560},             // widest dx
		'{1'b1, CMIN, Z, CMAX, Z, NA, 1048560},
		'{1'b0, Z, CMAX, Z, CMIN, NA, 1048560},             // widest dy
		'{1'b1, Z, CMIN, Z, CMAX, NA, 1048560},
		'{1'b0, CMAX, CMAX, CMIN, CMIN, NA, NA},            // longest distance
		'{1'b1, CMIN, CMIN, CMAX, CMAX, NA, NA},
		'{1'b0, CMAX, CMIN, CMIN, CMAX, NA, NA},
		'{1'b1, CMIN, CMAX, CMAX, CMIN, NA, NA},
		'{1'b0, 16'sd3, 16'sd4, Z, Z, NA, 80},
		'{1'b1, Z, Z, 16'sd3, 16'sd4, NA, 80},
		'{1'b0, 16'sd1, Z, Z, Z, NA, 16},                   // unit steps on axes
		'{1'b0, -16'sd1, Z, Z, Z, NA, 16},
		'{1'b0, Z, 16'sd1, Z, Z, NA, 16},
		'{1'b0, Z, -16'sd1, Z, Z, NA, 16},
		'{1'b1, -16'sd1, Z, Z, Z, NA, 16},
		'{1'b0, -16'sd5, 16'sd1, Z, Z, NA, NA},             // either side of 180
		'{1'b1, -16'sd5, -16'sd1, Z, Z, NA, NA},
		'{1'b0, CMAX, Z, CMIN, 16'sd1, NA, NA},             // rounds up to 360
		'{1'b1, CMIN, 16'sd1, CMAX, Z, NA, NA},
		'{1'b0, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, NA, NA}
	};

	logic               clk;
	logic               arst_n;
	logic               pt_valid;
	logic               pt_stall;
	logic               action;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] ref_x;
	logic signed [15:0] ref_y;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [15:0]        angle_deg;
	logic [20:0]        distance;

	polar_t pending_polar [$];
	int     send_idle;
	int     recv_idle;
	int     beats_sent;
	int     results_checked;
	int     errors;

	point_polar_angle_distance u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.action    (action),
		.point_x   (point_x),
		.point_y   (point_y),
		.ref_x     (ref_x),
		.ref_y     (ref_y),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.angle_deg (angle_deg),
		.distance  (distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Direction and length of (point - reference): vectoring CORDIC on a
	// binary angle, then a rounded integer square root.
	function automatic polar_t polar_of(input pt_beat_t b);
		longint      dx, dy, x, y, xs, ys, ax, ay;
		logic [31:0] acc;
		logic [63:0] ang, rad, n, r, bv;
		int          i;
		polar_t      res;
		dx  = longint'(b.px) - longint'(b.rx);
		dy  = longint'(b.py) - longint'(b.ry);
		acc = 32'd0;
		if (dx != 0 || dy != 0) begin
			x = dx <<< SCALE_SHIFT;
			y = dy <<< SCALE_SHIFT;
			// left half plane: fold over and start from 180 deg
			if (x < 0) begin
				x   = -x;
				y   = -y;
				acc = HALF_REV;
			end
			for (i = 0; i < ROTATIONS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x   = x + ys;
					y   = y - xs;
					acc = acc + ARCTAN_STEP[i];
				end else begin
					x   = x - ys;
					y   = y + xs;
					acc = acc - ARCTAN_STEP[i];
				end
			end
		end
		if (b.act)
			acc = acc + HALF_REV;
		ang = (64'(acc) * FULL_CIRC + 64'(HALF_REV)) >> 32;
		if (ang >= FULL_CIRC)
			ang = 64'd0;

		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax >= SAT_MAG || ay >= SAT_MAG) begin
			r = DIST_SAT;
		end else begin
			rad = 64'(256 * (ax * ax + ay * ay));
			n   = rad;
			r   = 64'd0;
			bv  = 64'd1 << 62;
			while (bv > n)
				bv = bv >> 2;
			while (bv != 0) begin
				if (n >= r + bv) begin
					n = n - (r + bv);
					r = (r >> 1) + bv;
				end else begin
					r = r >> 1;
				end
				bv = bv >> 2;
			end
			if (rad - r * r > r)
				r = r + 1;
			if (r > DIST_SAT)
				r = DIST_SAT;
		end
		res.angle  = ang[15:0];
		res.radius = r[20:0];
		return res;
	endfunction

	// Free random pairs half the time, else short differences, coincident points,
	// axis-aligned differences and corner values.
	function automatic pt_beat_t random_beat();
		pt_beat_t b;
		b.act = 1'($urandom_range(1));
		b.px  = 16'($urandom);
		b.py  = 16'($urandom);
		b.rx  = 16'($urandom);
		b.ry  = 16'($urandom);
		case ($urandom_range(9))
			5, 6: begin
				b.px = b.rx + 16'($urandom_range(511)) - 16'd256;
				b.py = b.ry + 16'($urandom_range(511)) - 16'd256;
			end
			7: begin
				b.px = b.rx;
				b.py = b.ry;
			end
			8: begin
				if ($urandom_range(1))
					b.px = b.rx;
				else
					b.py = b.ry;
			end
			9: begin
				b.px = EXTREMES[$urandom_range(3)];
				b.py = EXTREMES[$urandom_range(3)];
				b.rx = EXTREMES[$urandom_range(3)];
				b.ry = EXTREMES[$urandom_range(3)];
			end
			default: ;
		endcase
		return b;
	endfunction

	// Present one beat after a random gap and hold it until taken.
	task automatic send_beat(input pt_beat_t b, input polar_t want);
		while ($urandom_range(99) < send_idle) begin
			pt_valid <= 1'b0;
			@(posedge clk);
		end
		pt_valid <= 1'b1;
		action   <= b.act;
		point_x  <= b.px;
		point_y  <= b.py;
		ref_x    <= b.rx;
		ref_y    <= b.ry;
		do
			@(posedge clk);
		while (pt_stall);
		pending_polar.push_back(want);
		beats_sent++;
	endtask

	// Sender goes quiet until every pending result has come back.
	task automatic drain_results();
		pt_valid <= 1'b0;
		while (pending_polar.size() != 0)
			@(posedge clk);
	endtask

	// Result side: check the beat taken at this edge, then pick the next stall.
	always @(posedge clk) begin : res_check
		polar_t want;
		if (res_valid && !res_stall) begin
			if (pending_polar.size() == 0) begin
				$error("result beat with nothing pending: angle_deg %0d, distance %0d",
					angle_deg, distance);
				errors++;
			end else begin
				want = pending_polar.pop_front();
				if (angle_deg !== want.angle) begin
					$error("angle_deg: expected %0d, got %0d", want.angle, angle_deg);
					errors++;
				end
				if (distance !== want.radius) begin
					$error("distance: expected %0d, got %0d", want.radius, distance);
					errors++;
				end
				results_checked++;
			end
		end
		res_stall <= ($urandom_range(99) < recv_idle);
	end

	// Watchdog: too long without a beat on either channel means a hang.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pt_valid && !pt_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("[point_polar_angle_distance] ERROR");
		$finish;
	end

	initial begin : stimulus
		pt_beat_t beat;
		polar_t   want;
		int       idx;
		int       phase;
		int       k;
		beats_sent      = 0;
		results_checked = 0;
		errors          = 0;
		send_idle       = 26;
		recv_idle       = 71;
		arst_n   <= 1'b0;
		pt_valid <= 1'b0;
		action   <= 1'b0;
		point_x  <= '0;
		point_y  <= '0;
		ref_x    <= '0;
		ref_y    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed expectations override the predictor
		for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
			beat.act = DIRECTED[idx].act;
			beat.px  = DIRECTED[idx].px;
			beat.py  = DIRECTED[idx].py;
			beat.rx  = DIRECTED[idx].rx;
			beat.ry  = DIRECTED[idx].ry;
			want     = polar_of(beat);
			if (DIRECTED[idx].exp_angle != NA)
				want.angle = 16'(DIRECTED[idx].exp_angle);
			if (DIRECTED[idx].exp_dist != NA)
				want.radius = 21'(DIRECTED[idx].exp_dist);
			send_beat(beat, want);
		end
		drain_results();

		// slow receiver, then slow sender, then full rate
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 26;
					recv_idle = 71;
				end
				1: begin
					send_idle = 71;
					recv_idle = 26;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				beat = random_beat();
				send_beat(beat, polar_of(beat));
			end
			drain_results();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (pending_polar.size() != 0) begin
			$error("%0d expected results never arrived", pending_polar.size());
			errors++;
		end
		$display("%0d point pairs sent (%0d from the table), %0d results compared",
			beats_sent, DIRECTED_ROWS, results_checked);
		$display("idle patterns: slow sender, slow receiver, back to back; %0d mismatches",
			errors);
		if (errors == 0)
			$display("[point_polar_angle_distance] OK");
		else
			$display("[point_polar_angle_distance] ERROR");
		$finish;
	end

endmodule
